/* sv/tibt_pkg.sv */
package tibt_pkg;

  // widths of the item fields
  localparam int TIME_W = 64;
  localparam int KIND_W = 3;
  localparam int COUNT_OUT_W = 5;
  localparam int MAX_REGIONS_DEF = 16;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PAUSE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESUME = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SCALE  = 3'd4;

  // command handed from front to back
  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADD,
    OP_QUERY,
    OP_SCALE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] f;
  } cmd_t;

endpackage

/* sv/tibt_ram.sv */
module tibt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tibt_front.sv */
module tibt_front import tibt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [KIND_W-1:0] kind,
  input  logic [TIME_W-1:0] time_a,
  input  logic [TIME_W-1:0] time_b,
  input  logic [TIME_W-1:0] scale_factor,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  logic              pause_open;
  logic [TIME_W-1:0] pause_time;
  cmd_t              slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              accept;
  cmd_t              cmd_new;

  assign full      = (fill == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];

  // classify the incoming word into a back-end command
  always_comb begin
    cmd_new.op = OP_NOP;
    cmd_new.a  = time_a;
    cmd_new.b  = time_b;
    cmd_new.f  = scale_factor;
    unique case (kind)
      KIND_ADD:   cmd_new.op = OP_ADD;
      KIND_QUERY: cmd_new.op = OP_QUERY;
      KIND_SCALE: cmd_new.op = OP_SCALE;
      KIND_RESUME: begin
        if (pause_open) begin
          cmd_new.op = OP_ADD;
          cmd_new.a  = pause_time;
          cmd_new.b  = time_a;
        end
      end
      default: cmd_new.op = OP_NOP;
    endcase
  end

  // pause tracking and two-entry command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      pause_open <= 1'b0;
      pause_time <= '0;
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      fill       <= 2'd0;
    end else begin
      if (accept) begin
        slot[wr_ptr] <= cmd_new;
        wr_ptr       <= !wr_ptr;
        if (kind == KIND_PAUSE && !pause_open) begin
          pause_open <= 1'b1;
          pause_time <= time_a;
        end else if (kind == KIND_RESUME) begin
          pause_open <= 1'b0;
        end
      end
      if (cmd_pop && cmd_valid) begin
        rd_ptr <= !rd_ptr;
      end
      if (accept && !(cmd_pop && cmd_valid)) begin
        fill <= fill + 2'd1;
      end else if (!accept && cmd_pop && cmd_valid) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* sv/tibt_back.sv */
module tibt_back import tibt_pkg::*; #(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output logic                   empty,
  input  logic                   pop,
  output logic                   inside_res,
  output logic [COUNT_OUT_W-1:0] region_count,
  output logic                   dropped_full
);

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int EW = 2 * TIME_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QRUN,
    S_MUL0,
    S_MUL1,
    S_MUL2
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [IW-1:0]          idx;
  logic                   res_valid;
  logic [TIME_W-1:0]      qtime;
  logic [TIME_W-1:0]      fac;
  logic [TIME_W-1:0]      op_s;
  logic [TIME_W-1:0]      op_e;
  logic [TIME_W-1:0]      p_s;
  logic [TIME_W-1:0]      p_e;
  logic [31:0]            c_s;
  logic [31:0]            c_e;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [IW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;

  logic                   last;
  logic                   hit;
  logic                   table_full;
  logic [31:0]            m_s;
  logic [31:0]            m_e;
  logic [TIME_W-1:0]      new_s;
  logic [TIME_W-1:0]      new_e;
  logic [CW+COUNT_OUT_W-1:0] count_ext;

  tibt_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_REGIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result port
  assign empty        = !res_valid;
  assign count_ext    = (CW + COUNT_OUT_W)'(count);
  assign region_count = count_ext[COUNT_OUT_W-1:0];

  assign cmd_pop    = (state == S_IDLE) && cmd_valid && !res_valid;
  assign last       = (CW'(idx) == count - CW'(1));
  assign table_full = (count >= CW'(MAX_REGIONS));

  // membership test on the entry read last cycle
  assign hit = ($signed(qtime) >= $signed(ram_rdata[TIME_W-1:0])) &&
               ($signed(qtime) <  $signed(ram_rdata[EW-1:TIME_W]));

  // last partial product and 64-bit wrap sum of the scaled bounds
  assign m_s   = op_s[63:32] * fac[31:0];
  assign m_e   = op_e[63:32] * fac[31:0];
  assign new_s = p_s + {c_s + m_s, 32'd0};
  assign new_e = p_e + {c_e + m_e, 32'd0};

  // table port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {new_e, new_s};
    unique case (state)
      S_IDLE: begin
        ram_raddr = '0;
        ram_waddr = count[IW-1:0];
        ram_wdata = {cmd.b, cmd.a};
        ram_we    = cmd_pop && (cmd.op == OP_ADD) && !table_full;
      end
      S_QRUN:  ram_raddr = idx + IW'(1);
      S_MUL2: begin
        ram_raddr = idx + IW'(1);
        ram_we    = 1'b1;
      end
      default: ram_raddr = idx;
    endcase
  end

  // command sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            inside_res   <= 1'b0;
            dropped_full <= 1'b0;
            idx          <= '0;
            qtime        <= cmd.a;
            fac          <= cmd.f;
            unique case (cmd.op)
              OP_ADD: begin
                res_valid <= 1'b1;
                if (table_full) begin
                  dropped_full <= 1'b1;
                end else begin
                  count <= count + CW'(1);
                end
              end
              OP_QUERY: begin
                if (count == '0) begin
                  res_valid <= 1'b1;
                end else begin
                  state <= S_QRUN;
                end
              end
              OP_SCALE: begin
                if (count == '0) begin
                  res_valid <= 1'b1;
                end else begin
                  state <= S_MUL0;
                end
              end
              default: res_valid <= 1'b1;
            endcase
          end
        end
        S_QRUN: begin
          if (hit || last) begin
            inside_res <= hit;
            res_valid  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_MUL0: begin
          op_s  <= ram_rdata[TIME_W-1:0];
          op_e  <= ram_rdata[EW-1:TIME_W];
          p_s   <= ram_rdata[31:0] * fac[31:0];
          p_e   <= ram_rdata[TIME_W+31:TIME_W] * fac[31:0];
          state <= S_MUL1;
        end
        S_MUL1: begin
          c_s   <= op_s[31:0] * fac[63:32];
          c_e   <= op_e[31:0] * fac[63:32];
          state <= S_MUL2;
        end
        S_MUL2: begin
          if (last) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_MUL0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/time_interval_blackout_table.sv */
// add, pause, resume, unused kinds: front queue slot, then back-end result register
// query: visits entries in order, stops at the first hit, one table read per cycle
// scale: three 32x32 partial-product steps per entry on the table port
// words wait in a two-word queue while the back end is busy or holds an unpopped result
// reset: rst, synchronous, empties the table count, the queue, the open pause and the result
module time_interval_blackout_table import tibt_pkg::*; #(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [TIME_W-1:0] time_a,
  input  logic signed [TIME_W-1:0] time_b,
  input  logic signed [TIME_W-1:0] scale_factor,
  output logic                     empty,
  input  logic                     pop,
  output logic                     inside_res,
  output logic [COUNT_OUT_W-1:0]   region_count,
  output logic                     dropped_full
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: pause tracking and command queue
  tibt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .time_a       (time_a),
    .time_b       (time_b),
    .scale_factor (scale_factor),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // back: interval table and sequencer
  tibt_back #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .inside_res   (inside_res),
    .region_count (region_count),
    .dropped_full (dropped_full)
  );

endmodule
